FILE: rtl/stc_pkg.sv
// ---------------------------------------------------------------------------
// Sample-to-chunk lookup package
// Shared types and constants for the table memory, the walk datapath and the
// top level.
// ---------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

  localparam int STC_MAX_ENTRIES = 64;
  localparam int IDX_W           = 6;
  localparam int CNT_CFG_W       = 7;

  // Command codes carried on in_tuser.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register index decoded from cfg_paddr[2].
  localparam logic REG_ENTRY_COUNT = 1'b0;

  localparam logic [CNT_CFG_W-1:0] ENTRY_COUNT_RESET = 7'd1;

  typedef struct packed {
    logic [31:0] first_chunk;
    logic [31:0] samples;
  } entry_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic issue_last;
  } walk_ctrl_t;

  typedef struct packed {
    logic        done;
    logic [31:0] samples;
    logic [31:0] index;
    logic        ovf;
  } walk_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_WAIT,
    ST_HOLD
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/stc_table.sv
// ---------------------------------------------------------------------------
// Sample-to-chunk run table
// Simple dual-port synchronous memory holding one run entry per address, with
// a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module stc_table #(
  parameter int MAX_ENTRIES = stc_pkg::STC_MAX_ENTRIES,
  parameter int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [ADDR_W-1:0]   waddr,
  input  wire stc_pkg::entry_t     wdata,
  input  wire logic                re,
  input  wire logic [ADDR_W-1:0]   raddr,
  output stc_pkg::entry_t          rdata
);
  import stc_pkg::*;

  entry_t mem [MAX_ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/stc_walk.sv
// ---------------------------------------------------------------------------
// Sample-to-chunk walk datapath
// Evaluates each run entry against its successor as entries stream out of
// the table, forms the chunk span product and accumulates the saturated
// first-sample index.
// ---------------------------------------------------------------------------
`default_nettype none

module stc_walk (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire stc_pkg::walk_ctrl_t ctrl,
  input  wire logic [31:0]         chunk,
  input  wire stc_pkg::entry_t     rd_data,
  output stc_pkg::walk_res_t       res
);
  import stc_pkg::*;

  logic        rv_r, rl_r, tail_r;
  logic        have_prev_r;
  entry_t      prev_r;
  logic        samp_found_r, samp_found_nxt;
  logic [31:0] samp_r, samp_nxt;
  logic        idx_done_r, idx_done_nxt;
  logic [31:0] span;
  logic        eval_v;
  logic [63:0] prod_r;
  logic        pv_r, pl_r;
  logic [31:0] acc_r;
  logic        ovf_r;
  logic        done_r;
  logic [32:0] sum;
  logic [31:0] cur, nxt_first;

  // An entry is judged once its successor has been read; the last one in
  // use is judged in the cycle after it arrives.
  assign eval_v    = (rv_r && have_prev_r) || tail_r;
  assign cur       = prev_r.first_chunk;
  assign nxt_first = rd_data.first_chunk;

  always_comb begin
    samp_found_nxt = samp_found_r;
    samp_nxt       = samp_r;
    idx_done_nxt   = idx_done_r;
    span           = 32'd0;
    if (eval_v) begin
      if (!samp_found_r) begin
        if (tail_r || (chunk >= cur && chunk < nxt_first)) begin
          samp_found_nxt = 1'b1;
          samp_nxt       = prev_r.samples;
        end
      end
      if (!idx_done_r) begin
        if (tail_r) begin
          if (chunk > cur) begin
            span = chunk - cur;
          end
          idx_done_nxt = 1'b1;
        end else if (chunk > cur) begin
          if (chunk < nxt_first) begin
            span         = chunk - cur;
            idx_done_nxt = 1'b1;
          end else if (nxt_first > cur) begin
            span = nxt_first - cur;
          end
        end else if (chunk == cur) begin
          idx_done_nxt = 1'b1;
        end
      end
    end
  end

  assign sum = {1'b0, acc_r} + {1'b0, prod_r[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r         <= 1'b0;
      rl_r         <= 1'b0;
      tail_r       <= 1'b0;
      have_prev_r  <= 1'b0;
      samp_found_r <= 1'b0;
      idx_done_r   <= 1'b0;
      pv_r         <= 1'b0;
      pl_r         <= 1'b0;
      done_r       <= 1'b0;
      ovf_r        <= 1'b0;
      acc_r        <= 32'd0;
    end else begin
      rv_r   <= ctrl.issue;
      rl_r   <= ctrl.issue_last;
      tail_r <= rv_r && rl_r;
      pv_r   <= eval_v;
      pl_r   <= tail_r;
      done_r <= pv_r && pl_r;
      if (ctrl.start) begin
        have_prev_r  <= 1'b0;
        samp_found_r <= 1'b0;
        idx_done_r   <= 1'b0;
        acc_r        <= 32'd0;
        ovf_r        <= 1'b0;
      end else begin
        if (rv_r) begin
          have_prev_r <= 1'b1;
        end
        samp_found_r <= samp_found_nxt;
        idx_done_r   <= idx_done_nxt;
        if (pv_r) begin
          if (prod_r[63:32] != 32'd0 || sum[32]) begin
            acc_r <= 32'hFFFF_FFFF;
            ovf_r <= 1'b1;
          end else begin
            acc_r <= sum[31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rv_r) begin
      prev_r <= rd_data;
    end
    samp_r <= samp_nxt;
    prod_r <= 64'(prev_r.samples) * 64'(span);
  end

  assign res.done    = done_r;
  assign res.samples = samp_r;
  assign res.index   = acc_r;
  assign res.ovf     = ovf_r;

endmodule

`default_nettype wire

FILE: rtl/sample_to_chunk_lookup.sv
// ---------------------------------------------------------------------------
// Sample-to-chunk lookup
// Run table of first-chunk and samples-per-chunk entries, loaded by transfer,
// and a walk that answers chunk queries with sample count and first index.
// ---------------------------------------------------------------------------
// A load transfer (in_tuser = 0) writes one table entry and returns nothing;
// loads at or above MAX_ENTRIES are dropped. A query transfer (in_tuser = 1)
// reads the entries in use out of the table memory one per cycle, through
// the single read port of the table, and then offers its result. One result
// is held in the output register, so a further load can be taken while it
// waits; a query finishing while the previous result is still untaken holds
// the input side until out_tready frees the register.
`default_nettype none

module sample_to_chunk_lookup #(
  parameter int MAX_ENTRIES = stc_pkg::STC_MAX_ENTRIES
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // in_tdata: entry_index[5:0], first_chunk[37:6], samples_per_chunk[69:38],
  // chunk_number[101:70], zero padding[103:102]
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [103:0]  in_tdata,
  // in_tuser: command[0]
  input  wire logic          in_tuser,
  // out_tdata: samples_in_chunk[31:0], first_sample_index[63:32],
  // overflow[64], zero padding[71:65]
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [71:0]        out_tdata,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import stc_pkg::*;

  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_t               state_r, state_nxt;
  logic [CNT_CFG_W-1:0] entry_count_r;
  logic [ADDR_W-1:0]    rd_addr_r, last_r, last_nxt;
  logic [31:0]          chunk_r;
  logic                 out_tvalid_r;
  logic [71:0]          out_data_r;

  logic                 in_accept, mem_we, out_free, out_load;
  logic [5:0]           in_idx;
  entry_t               wr_entry, rd_entry;
  walk_ctrl_t           ctrl;
  walk_res_t            res;
  logic [31:0]          ec32, n32;

  assign in_idx               = in_tdata[5:0];
  assign wr_entry.first_chunk = in_tdata[37:6];
  assign wr_entry.samples     = in_tdata[69:38];

  assign in_accept = in_tvalid && in_tready;
  assign mem_we    = in_accept && (in_tuser == CMD_LOAD) &&
                     ({26'd0, in_idx} < 32'(MAX_ENTRIES));
  assign out_free  = !out_tvalid_r || out_tready;

  // Entry count of zero counts as one, above the table depth as the depth.
  always_comb begin
    ec32 = {25'd0, entry_count_r};
    if (ec32 == 32'd0) begin
      n32 = 32'd1;
    end else if (ec32 > 32'(MAX_ENTRIES)) begin
      n32 = 32'(MAX_ENTRIES);
    end else begin
      n32 = ec32;
    end
    last_nxt = ADDR_W'(n32 - 32'd1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_tuser == CMD_QUERY) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_addr_r == last_r) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (res.done) begin
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready       = 1'b0;
    ctrl.start      = 1'b0;
    ctrl.issue      = 1'b0;
    ctrl.issue_last = 1'b0;
    out_load        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        ctrl.start = in_tvalid && (in_tuser == CMD_QUERY);
      end
      ST_WALK: begin
        ctrl.issue      = 1'b1;
        ctrl.issue_last = (rd_addr_r == last_r);
      end
      ST_WAIT: out_load = res.done && out_free;
      ST_HOLD: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= ENTRY_COUNT_RESET;
      out_tvalid_r  <= 1'b0;
      rd_addr_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_ENTRY_COUNT) begin
        entry_count_r <= cfg_pwdata[CNT_CFG_W-1:0];
      end
      if (ctrl.start) begin
        rd_addr_r <= '0;
      end else if (ctrl.issue) begin
        rd_addr_r <= rd_addr_r + ADDR_W'(1);
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      chunk_r <= in_tdata[101:70];
      last_r  <= last_nxt;
    end
    if (out_load) begin
      out_data_r <= {7'd0, res.ovf, res.index, res.samples};
    end
  end

  stc_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ADDR_W'({26'd0, in_idx})),
    .wdata (wr_entry),
    .re    (ctrl.issue),
    .raddr (rd_addr_r),
    .rdata (rd_entry)
  );

  stc_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .chunk   (chunk_r),
    .rd_data (rd_entry),
    .res     (res)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ENTRY_COUNT) ? {25'd0, entry_count_r} : 32'd0;

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> state_r == ST_WAIT)
    else $error("walk finished outside the wait state");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.issue |-> rd_addr_r <= last_r)
    else $error("table read beyond the last entry in use");

  a_no_load_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_IDLE)
    else $error("table written while a query is walking");

  a_out_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(out_load))
    else $error("result offered without a finished walk");
`endif

endmodule

`default_nettype wire
